[hw/rtl/ude_pkg.sv]
// Package for the 32-bit unsigned to decimal ASCII emitter.
// Holds the shared widths, the ASCII base code and the beat structs between stages.
// Depends on nothing.
package ude_pkg;

    localparam int NUM_W       = 32;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = DIGIT_W * NUM_DIGITS;
    localparam int STAGE_BITS  = 4;
    localparam int NUM_STAGES  = NUM_W / STAGE_BITS;
    localparam int COUNT_W     = 4;
    localparam int CHAR_W      = 6;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    // One item partway through the shift-and-add-3 conversion.
    typedef struct packed {
        logic               valid;
        logic [BCD_W-1:0]   bcd;
        logic [NUM_W-1:0]   bin;
    } ude_dab_t;

    // One converted item, digits left aligned, with its digit count.
    typedef struct packed {
        logic               valid;
        logic [BCD_W-1:0]   digits;
        logic [COUNT_W-1:0] count;
    } ude_run_t;

endpackage

[hw/rtl/ude_dabble_stage.sv]
// One register stage of the binary to BCD conversion: four shift-and-add-3 steps.
// Depends on ude_pkg.
module ude_dabble_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  ude_pkg::ude_dab_t d_in,
    output ude_pkg::ude_dab_t d_out
);

    logic                       valid_reg;
    logic [ude_pkg::BCD_W-1:0]  bcd_reg;
    logic [ude_pkg::NUM_W-1:0]  bin_reg;
    logic [ude_pkg::BCD_W-1:0]  bcd_next;
    logic [ude_pkg::NUM_W-1:0]  bin_next;

    always_comb
    begin
        bcd_next = d_in.bcd;
        bin_next = d_in.bin;
        for (int it = 0; it < ude_pkg::STAGE_BITS; it++)
        begin
            for (int d = 0; d < ude_pkg::NUM_DIGITS; d++)
            begin
                if (bcd_next[d*ude_pkg::DIGIT_W +: ude_pkg::DIGIT_W] >= ude_pkg::DABBLE_MIN)
                begin
                    bcd_next[d*ude_pkg::DIGIT_W +: ude_pkg::DIGIT_W] =
                        bcd_next[d*ude_pkg::DIGIT_W +: ude_pkg::DIGIT_W] + ude_pkg::DABBLE_ADD;
                end
            end
            bcd_next = {bcd_next[ude_pkg::BCD_W-2:0], bin_next[ude_pkg::NUM_W-1]};
            bin_next = {bin_next[ude_pkg::NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

    assign d_out.valid = valid_reg;
    assign d_out.bcd   = bcd_reg;
    assign d_out.bin   = bin_reg;

endmodule

[hw/rtl/ude_align.sv]
// Register stage that counts significant digits and shifts the leading digit to the top.
// Depends on ude_pkg.
module ude_align
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  ude_pkg::ude_dab_t d_in,
    output ude_pkg::ude_run_t r_out
);

    logic                         valid_reg;
    logic [ude_pkg::BCD_W-1:0]    digits_reg;
    logic [ude_pkg::COUNT_W-1:0]  count_reg;
    logic [ude_pkg::COUNT_W-1:0]  count_next;
    logic [ude_pkg::BCD_W-1:0]    digits_next;
    logic [5:0]                   shamt;

    // Zero still yields one digit, so the count starts at one.
    always_comb
    begin
        count_next = ude_pkg::COUNT_W'(1);
        for (int i = 1; i < ude_pkg::NUM_DIGITS; i++)
        begin
            if (d_in.bcd[i*ude_pkg::DIGIT_W +: ude_pkg::DIGIT_W] != '0)
            begin
                count_next = ude_pkg::COUNT_W'(i + 1);
            end
        end
        shamt       = {ude_pkg::COUNT_W'(ude_pkg::NUM_DIGITS) - count_next, 2'b00};
        digits_next = d_in.bcd << shamt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            digits_reg <= digits_next;
            count_reg  <= count_next;
        end
    end

    assign r_out.valid  = valid_reg;
    assign r_out.digits = digits_reg;
    assign r_out.count  = count_reg;

endmodule

[hw/rtl/ude_serializer.sv]
// Emits the digits of one converted item as ASCII beats through an output register.
// Depends on ude_pkg.
module ude_serializer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ude_pkg::ude_run_t           r_in,
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ude_pkg::CHAR_W-1:0]  digit_char,
    output logic                        last_digit
);

    logic                         ser_valid_reg;
    logic [ude_pkg::BCD_W-1:0]    ser_digits_reg;
    logic [ude_pkg::COUNT_W-1:0]  ser_left_reg;
    logic                         out_valid_reg;
    logic [ude_pkg::CHAR_W-1:0]   char_reg;
    logic                         last_reg;
    logic                         out_take;
    logic                         emit;
    logic                         is_last;
    logic [ude_pkg::DIGIT_W-1:0]  top_digit;

    assign out_take  = !out_valid_reg || !out_stall;
    assign emit      = ser_valid_reg && out_take;
    assign is_last   = (ser_left_reg == ude_pkg::COUNT_W'(1));
    assign free      = !ser_valid_reg || (emit && is_last);
    assign top_digit = ser_digits_reg[ude_pkg::BCD_W-1 -: ude_pkg::DIGIT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free)
            begin
                ser_valid_reg <= r_in.valid;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free)
        begin
            ser_digits_reg <= r_in.digits;
            ser_left_reg   <= r_in.count;
        end
        else if (emit)
        begin
            ser_digits_reg <= {ser_digits_reg[ude_pkg::BCD_W-ude_pkg::DIGIT_W-1:0],
                               {ude_pkg::DIGIT_W{1'b0}}};
            ser_left_reg   <= ser_left_reg - ude_pkg::COUNT_W'(1);
        end
        if (emit)
        begin
            char_reg <= ude_pkg::ASCII_ZERO + ude_pkg::CHAR_W'(top_digit);
            last_reg <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

endmodule

[hw/rtl/u32_decimal_ascii_emitter.sv]
// Top level of the 32-bit unsigned to decimal ASCII emitter.
// Depends on ude_pkg, ude_dabble_stage, ude_align and ude_serializer.
//
// Usage:
// The input channel (in_valid, in_stall, number) takes one 32-bit unsigned value per beat.
// The output channel (out_valid, out_stall, digit_char, last_digit) gives its decimal text,
// most significant digit first, one ASCII character per beat. Leading zeros are dropped, so
// zero gives the single character '0'. last_digit marks the final character of each value.
// A value passes eight conversion stages of four shift-and-add-3 steps each, one alignment
// stage that counts digits, and a serializer with an output register. A value can be
// accepted in every cycle; the sustained rate is set by the serializer, which sends one
// character per cycle while out_stall is low, so a value holds it until its last digit is
// sent; a value has one to ten digits. While the serializer is busy, in_stall rises once
// the alignment stage holds a value; the conversion and alignment stages then hold their
// contents.
// When the receiver raises out_stall, the output register keeps its beat unchanged and the
// serializer and conversion stages back up behind it; nothing is lost or repeated.
// Reset clears every valid bit, so no beat appears on the output until a value is accepted.
module u32_decimal_ascii_emitter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ude_pkg::NUM_W-1:0]   number,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ude_pkg::CHAR_W-1:0]  digit_char,
    output logic                        last_digit
);

    ude_pkg::ude_dab_t dab [ude_pkg::NUM_STAGES+1];
    ude_pkg::ude_run_t run;
    logic              ser_free;
    logic              pipe_adv;

    // The whole conversion pipeline moves together; it may always move when its
    // last register is empty, so bubbles are squeezed out there.
    assign pipe_adv = !run.valid || ser_free;
    assign in_stall = !pipe_adv;

    assign dab[0].valid = in_valid;
    assign dab[0].bcd   = '0;
    assign dab[0].bin   = number;

    for (genvar s = 0; s < ude_pkg::NUM_STAGES; s++)
    begin : g_dabble
        ude_dabble_stage u_stage
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (pipe_adv),
            .d_in  (dab[s]),
            .d_out (dab[s+1])
        );
    end

    ude_align u_align
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (pipe_adv),
        .d_in  (dab[ude_pkg::NUM_STAGES]),
        .r_out (run)
    );

    ude_serializer u_ser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .r_in       (run),
        .free       (ser_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

[hw/rtl/ude_checker.sv]
// Port-level checker for the decimal ASCII emitter, bound to the top level.
// Depends on ude_pkg and u32_decimal_ascii_emitter.
module ude_port_checks
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [ude_pkg::NUM_W-1:0]   number,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [ude_pkg::CHAR_W-1:0]  digit_char,
    input logic                        last_digit
);

    localparam logic [ude_pkg::CHAR_W-1:0] ASCII_NINE = ude_pkg::ASCII_ZERO + 6'd9;

    logic                         run_start_reg;
    logic [ude_pkg::COUNT_W-1:0]  run_len_reg;
    logic                         out_beat;

    assign out_beat = out_valid && !out_stall;

    // Tracks whether the next output beat opens a new value, and how many
    // characters of the current value have gone out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg <= 1'b1;
            run_len_reg   <= '0;
        end
        else if (out_beat)
        begin
            run_start_reg <= last_digit;
            run_len_reg   <= last_digit ? '0 : run_len_reg + ude_pkg::COUNT_W'(1);
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(number))
        else $error("input beat changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digit_char) && $stable(last_digit))
        else $error("output beat changed while stalled");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_char >= ude_pkg::ASCII_ZERO && digit_char <= ASCII_NINE)
        else $error("character is not a decimal digit");

    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_start_reg && digit_char == ude_pkg::ASCII_ZERO |-> last_digit)
        else $error("leading zero in decimal text");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_digit |-> run_len_reg < ude_pkg::COUNT_W'(ude_pkg::NUM_DIGITS - 1))
        else $error("decimal text longer than ten characters");

endmodule

bind u32_decimal_ascii_emitter ude_port_checks u_ude_port_checks
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .number     (number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last_digit (last_digit)
);

[verif/ude_checker.sv]
`timescale 1ns / 100ps
// Checker for the 32-bit unsigned to decimal ASCII emitter.
// Watches both channels, predicts the digit beats of every accepted value and compares them.
// Depends on ude_pkg for the character width and the ASCII base code.
module ude_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [ude_pkg::NUM_W-1:0]   number,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [ude_pkg::CHAR_W-1:0]  digit_char,
    input  logic                        last_digit,
    output int                          fail_count,
    output int                          digits_awaited
);

    // Holds far more beats than a whole run can leave outstanding.
    localparam int BEAT_DEPTH = 4096;

    typedef struct packed {
        logic [ude_pkg::CHAR_W-1:0] code;
        logic                       last;
    } digit_beat_t;

    digit_beat_t beat_store[BEAT_DEPTH];
    int          wr_count   = 0;
    int          rd_count   = 0;
    int          mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Splits a value into decimal digits and queues them most significant first.
    function automatic void queue_decimal_digits(input logic [ude_pkg::NUM_W-1:0] value);
        logic [3:0]                 lsd_first[10];
        logic [ude_pkg::NUM_W-1:0]  rest;
        int                         count;
        digit_beat_t                beat;
        rest  = value;
        count = 0;
        do
        begin
            lsd_first[count] = 4'(rest % 10);
            rest             = rest / 10;
            count++;
        end
        while (rest != 0 && count < 10);
        for (int k = count - 1; k >= 0; k--)
        begin
            beat.code = ude_pkg::ASCII_ZERO + ude_pkg::CHAR_W'(lsd_first[k]);
            beat.last = (k == 0);
            beat_store[wr_count % BEAT_DEPTH] = beat;
            wr_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        digit_beat_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (wr_count == rd_count)
                begin
                    report_mismatch("unexpected beat, digit_char", digit_char, -1);
                end
                else
                begin
                    want = beat_store[rd_count % BEAT_DEPTH];
                    rd_count++;
                    if (digit_char !== want.code)
                    begin
                        report_mismatch("digit_char", digit_char, want.code);
                    end
                    if (last_digit !== want.last)
                    begin
                        report_mismatch("last_digit", last_digit, want.last);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                queue_decimal_digits(number);
            end
        end
        digits_awaited <= wr_count - rd_count;
    end

endmodule

[verif/u32_decimal_ascii_emitter_test.sv]
`timescale 1ns / 100ps
// Testbench top for the 32-bit unsigned to decimal ASCII emitter.
// Drives values into the block and stalls its output; ude_checker does the prediction.
// Depends on ude_pkg, ude_checker and the block itself.
module u32_decimal_ascii_emitter_test;

    localparam int  RANDOM_VALUES = 107;
    // Tail wait after the last digits have drained, before the result is read.
    localparam int  SETTLE_CYCLES = 30;
    localparam int  CYCLE_LIMIT   = 200000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [ude_pkg::NUM_W-1:0]   number;
    logic                        out_valid;
    logic                        out_stall;
    logic [ude_pkg::CHAR_W-1:0]  digit_char;
    logic                        last_digit;

    int   fail_count;
    int   digits_awaited;
    int   cycle_count;
    // While steady is set, neither the sender nor the receiver takes a break.
    logic steady;

    u32_decimal_ascii_emitter u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .number     (number),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    ude_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .number         (number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digit_char     (digit_char),
        .last_digit     (last_digit),
        .fail_count     (fail_count),
        .digits_awaited (digits_awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // The receiver stalls in about a quarter of the cycles, independent of out_valid,
    // so stalls land on the first, middle and last digit of a run alike.
    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < 24);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Presents one value and holds it until the block takes the beat. Idle cycles in front
    // of it drop in_valid and put noise on the payload; in_valid is never dropped and raised
    // in the same step, so back-to-back beats keep it high.
    task automatic send_value(input logic [ude_pkg::NUM_W-1:0] value);
        while (!steady && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            number   <= $urandom;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Holds the input idle until every queued digit has left the block. The count from the
    // checker is registered, so the loop waits on the clock before each look at it.
    task automatic drain_digits();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (digits_awaited != 0);
    endtask

    // Picks a value with the given number of decimal digits, clipped to 32 bits.
    function automatic logic [ude_pkg::NUM_W-1:0] value_with_digits(input int digits);
        longint unsigned floor_value;
        longint unsigned ceil_value;
        floor_value = 1;
        for (int k = 1; k < digits; k++)
        begin
            floor_value = floor_value * 10;
        end
        ceil_value = floor_value * 10 - 1;
        if (digits == 1)
        begin
            floor_value = 0;
        end
        if (ceil_value > 64'hFFFF_FFFF)
        begin
            ceil_value = 64'hFFFF_FFFF;
        end
        return ude_pkg::NUM_W'(floor_value + (longint'($urandom) % (ceil_value - floor_value + 1)));
    endfunction

    initial
    begin
        logic [ude_pkg::NUM_W-1:0] corner_values[$];
        steady      = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        number      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero alone, the digit-count boundaries up to 10000 and from 10^8 on, the
        // full 32-bit range and alternating bit patterns so that every input bit is seen at both levels.
        corner_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                          32'd9999, 32'd10000, 32'd99999999, 32'd100000000, 32'd999999999,
                          32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890,
                          32'd4000000000, 32'd0};
        foreach (corner_values[i])
        begin
            send_value(corner_values[i]);
        end

        // The sender waits here until the block has emitted everything so far.
        drain_digits();

        // Random part: mostly values of a random digit count, so short and long runs mix
        // evenly, plus some values over the whole range. A stretch in the middle runs with
        // no idling on either side.
        for (int n = 0; n < RANDOM_VALUES; n++)
        begin
            steady = (n >= 50 && n < 80);
            if ($urandom_range(99) < 15)
            begin
                send_value($urandom);
            end
            else
            begin
                send_value(value_with_digits($urandom_range(1, 10)));
            end
        end
        steady = 1'b0;

        drain_digits();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/ude_pkg.sv
hw/rtl/ude_dabble_stage.sv
hw/rtl/ude_align.sv
hw/rtl/ude_serializer.sv
hw/rtl/u32_decimal_ascii_emitter.sv
hw/rtl/ude_checker.sv
verif/ude_checker.sv
verif/u32_decimal_ascii_emitter_test.sv
